// File: hdl/vcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vcs_pkg
// Shared widths, phase codes and the command and status structs that join
// the controller and the datapath of the cosine similarity block.
// ----------------------------------------------------------------------------
package vcs_pkg;

	localparam int ELEM_W = 16;
	localparam int DOT_W  = 42;
	localparam int SQ_W   = 41;
	localparam int LIMB_W = 21;
	localparam int PROD_W = LIMB_W + 32;
	localparam int ACC_W  = PROD_W + 3 * LIMB_W;
	localparam int P_W    = 4 * LIMB_W;
	localparam int M_W    = 16;
	localparam int K_W    = 4;

	// Product phases of the final computation.
	localparam logic [1:0] PH_NORM = 2'd0; // product of the two sums of squares
	localparam logic [1:0] PH_DOT  = 2'd1; // square of the dot magnitude
	localparam logic [1:0] PH_TEST = 2'd2; // norm product times a trial square

	typedef struct packed {
		logic             acc_in;    // add an element pair to the sums
		logic             start;     // begin the final computation
		logic             mul_en;    // issue one limb product
		logic [1:0]       ph;
		logic [1:0]       cnt;
		logic             save;      // close a product phase
		logic             odd_en;    // form the trial odd square
		logic [K_W-1:0]   k;
		logic             fin_load;  // load the result beat, clear the sums
	} cmd_t;

	typedef struct packed {
		logic degen;
		logic cmp_le;
	} sts_t;

endpackage : vcs_pkg
`default_nettype wire

// File: hdl/vcs_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vcs_datapath
// Accumulators, a shared 21x32 limb multiplier with a wide accumulator, and
// the bit-by-bit search for the rounded similarity magnitude.
// ----------------------------------------------------------------------------
module vcs_datapath (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire logic signed [vcs_pkg::ELEM_W-1:0] elem_a,
	input  wire logic signed [vcs_pkg::ELEM_W-1:0] elem_b,
	input  wire vcs_pkg::cmd_t               cmd,
	output vcs_pkg::sts_t                    sts,
	output logic signed [vcs_pkg::ELEM_W-1:0] similarity,
	output logic                             degenerate
);
	import vcs_pkg::*;

	localparam logic signed [DOT_W-1:0] DOT_BOUND = DOT_W'(64'sd1 <<< 40);
	localparam logic [SQ_W-1:0]          SQ_BOUND  = SQ_W'(64'd1 << 40);

	logic signed [DOT_W-1:0] dot_q;
	logic [SQ_W-1:0]         sa_q, sb_q;
	logic signed [31:0]      ab, aa, bb;
	logic signed [DOT_W-1:0] dot_sum;
	logic [SQ_W-1:0]         sa_sum, sb_sum;
	logic [DOT_W-1:0]        dabs;
	logic                    neg;
	logic [P_W-1:0]          p_q;
	logic [P_W-1:0]          dsq_q;
	logic [31:0]             odd2_q;
	logic [M_W-1:0]          m_q, trial, odd;
	logic [ACC_W-1:0]        acc_q, prod_sh;
	logic [PROD_W-1:0]       prod_q;
	logic [1:0]              shift_q;
	logic                    pv_q;
	logic [LIMB_W-1:0]       a_op;
	logic [31:0]             b_op;
	logic [1:0]              shift;
	logic [2*LIMB_W-1:0]     sa_x, sb_x;
	logic [ELEM_W-1:0]       sim_pos;

	// Element products and saturating sums.
	assign ab = elem_a * elem_b;
	assign aa = elem_a * elem_a;
	assign bb = elem_b * elem_b;
	assign dot_sum = dot_q + DOT_W'(ab);
	assign sa_sum  = sa_q + SQ_W'($unsigned(aa));
	assign sb_sum  = sb_q + SQ_W'($unsigned(bb));

	assign neg  = dot_q[DOT_W-1];
	assign dabs = neg ? $unsigned(-dot_q) : $unsigned(dot_q);
	assign sa_x = {1'b0, sa_q};
	assign sb_x = {1'b0, sb_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q <= '0;
			sa_q  <= '0;
			sb_q  <= '0;
		end else if (cmd.fin_load) begin
			dot_q <= '0;
			sa_q  <= '0;
			sb_q  <= '0;
		end else if (cmd.acc_in) begin
			if (dot_sum > DOT_BOUND)
				dot_q <= DOT_BOUND;
			else if (dot_sum < -DOT_BOUND)
				dot_q <= -DOT_BOUND;
			else
				dot_q <= dot_sum;
			sa_q <= (sa_sum > SQ_BOUND) ? SQ_BOUND : sa_sum;
			sb_q <= (sb_sum > SQ_BOUND) ? SQ_BOUND : sb_sum;
		end
	end

	// Operand selection for the shared limb multiplier.
	always_comb begin
		a_op  = '0;
		b_op  = '0;
		shift = '0;
		case (cmd.ph)
			PH_NORM: begin
				a_op  = cmd.cnt[0] ? sa_x[2*LIMB_W-1:LIMB_W] : sa_x[LIMB_W-1:0];
				b_op  = 32'(cmd.cnt[1] ? sb_x[2*LIMB_W-1:LIMB_W] : sb_x[LIMB_W-1:0]);
				shift = 2'(cmd.cnt[0]) + 2'(cmd.cnt[1]);
			end
			PH_DOT: begin
				a_op  = cmd.cnt[0] ? dabs[2*LIMB_W-1:LIMB_W] : dabs[LIMB_W-1:0];
				b_op  = 32'(cmd.cnt[1] ? dabs[2*LIMB_W-1:LIMB_W] : dabs[LIMB_W-1:0]);
				shift = 2'(cmd.cnt[0]) + 2'(cmd.cnt[1]);
			end
			PH_TEST: begin
				a_op  = p_q[cmd.cnt*LIMB_W +: LIMB_W];
				b_op  = odd2_q;
				shift = cmd.cnt;
			end
			default: begin
				a_op  = '0;
				b_op  = '0;
				shift = '0;
			end
		endcase
	end

	// Product register, then the shifted add into the accumulator.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pv_q <= 1'b0;
		else
			pv_q <= cmd.mul_en;
	end

	always_ff @(posedge clk) begin
		prod_q  <= PROD_W'(a_op) * PROD_W'(b_op);
		shift_q <= shift;
	end

	always_comb begin
		case (shift_q)
			2'd0:    prod_sh = ACC_W'(prod_q);
			2'd1:    prod_sh = ACC_W'(prod_q) << LIMB_W;
			2'd2:    prod_sh = ACC_W'(prod_q) << (2 * LIMB_W);
			default: prod_sh = ACC_W'(prod_q) << (3 * LIMB_W);
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.start || cmd.save)
			acc_q <= '0;
		else if (pv_q)
			acc_q <= acc_q + prod_sh;
	end

	// Trial value and the test against the squared dot product.
	assign trial = m_q | (M_W'(1) << cmd.k);
	assign odd   = {trial[M_W-2:0], 1'b0} - M_W'(1);
	assign sts.cmp_le = acc_q <= {dsq_q, 32'd0};
	assign sts.degen  = (sa_q == '0) || (sb_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.odd_en)
			odd2_q <= 32'(odd) * 32'(odd);
		if (cmd.save && cmd.ph == PH_NORM)
			p_q <= acc_q[P_W-1:0];
		if (cmd.save && cmd.ph == PH_DOT)
			dsq_q <= acc_q[P_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_q <= '0;
		else if (cmd.start)
			m_q <= '0;
		else if (cmd.save && cmd.ph == PH_TEST && sts.cmp_le)
			m_q <= trial;
	end

	// Result beat: sign, saturation at the top, zero for a zero norm.
	assign sim_pos = m_q[M_W-1] ? 16'h7FFF : m_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			similarity <= '0;
			degenerate <= 1'b0;
		end else if (cmd.fin_load) begin
			degenerate <= sts.degen;
			if (sts.degen)
				similarity <= '0;
			else if (neg)
				similarity <= $signed(-m_q);
			else
				similarity <= $signed(sim_pos);
		end
	end

endmodule : vcs_datapath
`default_nettype wire

// File: hdl/vcs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vcs_ctrl
// Controller: takes element beats, then sequences the limb products and up to
// sixteen trial tests of the final step, and holds the result beat valid.
// ----------------------------------------------------------------------------
module vcs_ctrl (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	input  wire                    last_elem,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire                    out_ready,
	input  wire vcs_pkg::sts_t     sts,
	output vcs_pkg::cmd_t          cmd
);
	import vcs_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHK   = 3'd1;
	localparam logic [2:0] S_MUL   = 3'd2;
	localparam logic [2:0] S_DRAIN = 3'd3;
	localparam logic [2:0] S_SAVE  = 3'd4;
	localparam logic [2:0] S_ODD   = 3'd5;
	localparam logic [2:0] S_FIN   = 3'd6;

	logic [2:0]     state_q, state_d;
	logic [1:0]     ph_q, ph_d, cnt_q, cnt_d;
	logic [K_W-1:0] k_q, k_d;
	logic           out_valid_q;

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		ph_d    = ph_q;
		cnt_d   = cnt_q;
		k_d     = k_q;
		cmd     = '0;
		cmd.ph  = ph_q;
		cmd.cnt = cnt_q;
		cmd.k   = k_q;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready   = 1'b1;
				cmd.acc_in = in_valid;
				if (in_valid && last_elem)
					state_d = S_CHK;
			end
			S_CHK: begin
				cmd.start = 1'b1;
				ph_d      = PH_NORM;
				cnt_d     = '0;
				state_d   = sts.degen ? S_FIN : S_MUL;
			end
			S_MUL: begin
				cmd.mul_en = 1'b1;
				cnt_d      = cnt_q + 2'd1;
				if (cnt_q == 2'd3)
					state_d = S_DRAIN;
			end
			S_DRAIN: begin
				state_d = S_SAVE;
			end
			S_SAVE: begin
				cmd.save = 1'b1;
				case (ph_q)
					PH_NORM: begin
						ph_d    = PH_DOT;
						state_d = S_MUL;
					end
					PH_DOT: begin
						ph_d    = PH_TEST;
						k_d     = K_W'(M_W - 1);
						state_d = S_ODD;
					end
					default: begin
						if (k_q == '0 || (sts.cmp_le && k_q == K_W'(M_W - 1)))
							state_d = S_FIN;
						else begin
							k_d     = k_q - K_W'(1);
							state_d = S_ODD;
						end
					end
				endcase
			end
			S_ODD: begin
				cmd.odd_en = 1'b1;
				state_d    = S_MUL;
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.fin_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ph_q        <= PH_NORM;
			cnt_q       <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			ph_q        <= ph_d;
			cnt_q       <= cnt_d;
			k_q         <= k_d;
			out_valid_q <= cmd.fin_load || (out_valid_q && !out_ready);
		end
	end

	assign out_valid = out_valid_q;

	// A loaded result is offered in the next cycle.
	a_fin_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin_load |=> out_valid_q)
		else $error("result beat not offered after load");

	// No element beat is taken while the multiplier is busy.
	a_mul_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul_en |-> !in_ready)
		else $error("input taken during final computation");

	// Once the top trial passes, no further trial is formed.
	a_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SAVE && ph_q == PH_TEST && sts.cmp_le && k_q == K_W'(M_W - 1))
		|=> state_q == S_FIN)
		else $error("search continued past full scale");

endmodule : vcs_ctrl
`default_nettype wire

// File: hdl/vector_cosine_similarity.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vector_cosine_similarity
// Streams element pairs into a dot product and two sums of squares and, on
// the last pair, emits the rounded Q1.15 cosine similarity.
// ----------------------------------------------------------------------------
//  Channel  Handshake             Beat contents
//  in       in_valid / in_ready   elem_a, elem_b, last_elem
//  out      out_valid / out_ready similarity, degenerate
//
// Element beats are taken one per cycle while the block is idle.
// After the last beat a zero norm goes straight to the result beat;
// otherwise two 4-limb products and up to 16 trials follow, all on the
// one shared 21x32 limb multiplier.
// Reset clears the sums and the output valid; no memory is cleared.
// A waiting result beat holds the block only when the next result is ready.
module vector_cosine_similarity (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               in_valid,
	output logic                              in_ready,
	input  wire logic signed [vcs_pkg::ELEM_W-1:0] elem_a,
	input  wire logic signed [vcs_pkg::ELEM_W-1:0] elem_b,
	input  wire                               last_elem,
	output logic                              out_valid,
	input  wire                               out_ready,
	output logic signed [vcs_pkg::ELEM_W-1:0] similarity,
	output logic                              degenerate
);
	import vcs_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Sequencer.
	vcs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last_elem (last_elem),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Arithmetic.
	vcs_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.elem_a     (elem_a),
		.elem_b     (elem_b),
		.cmd        (cmd),
		.sts        (sts),
		.similarity (similarity),
		.degenerate (degenerate)
	);

endmodule : vector_cosine_similarity
`default_nettype wire
